@@ rtl/tmhq_pkg.sv @@
`default_nettype none

package tmhq_pkg;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_PEEK   = 2'd2;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	localparam int CAP_W   = 7;
	localparam int COUNT_W = 7;

	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/tmhq_cell.sv @@
`default_nettype none

// One slot of the sorted chain: largest key at slot 0, valid slots contiguous.
module tmhq_cell import tmhq_pkg::*; #(
	parameter int KEY_WIDTH = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire cell_ctrl_t      ctrl,
	input  wire [KEY_WIDTH-1:0]  key,
	input  wire [KEY_WIDTH-1:0]  prev_key,
	input  wire                  prev_vld,
	input  wire                  prev_ge,
	input  wire [KEY_WIDTH-1:0]  next_key,
	input  wire                  next_vld,
	output logic [KEY_WIDTH-1:0] cell_key,
	output logic                 cell_vld,
	output logic                 cell_ge
);

	logic [KEY_WIDTH-1:0] key_q;
	logic                 vld_q;

	assign cell_key = key_q;
	assign cell_vld = vld_q;
	assign cell_ge  = vld_q && ($signed(key_q) >= $signed(key));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.ins && !cell_ge) begin
			vld_q <= prev_ge ? 1'b1 : prev_vld;
		end else if (ctrl.rem) begin
			vld_q <= next_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins && !cell_ge) begin
			key_q <= prev_ge ? key : prev_key;
		end else if (ctrl.rem) begin
			key_q <= next_key;
		end
	end

endmodule

`default_nettype wire

@@ rtl/ternary_max_heap_queue.sv @@
// Results are registered, valid in the cycle after the transaction is accepted.
// Throughput: one transaction per cycle unless in_stall is high; every slot of
// the sorted cell chain shifts or holds in the same cycle for insert, remove, peek.
// Reset (arst_n low, asynchronous): queue empty, capacity limit 64,
// no result pending. No clearing pass is needed.
`default_nettype none

module ternary_max_heap_queue import tmhq_pkg::*; #(
	parameter int DEPTH     = 64,
	parameter int KEY_WIDTH = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [CAP_W-1:0]      cfg_wdata,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire [1:0]            req_type,
	input  wire [KEY_WIDTH-1:0]  value,
	output logic                 out_valid,
	input  wire                  out_stall,
	output logic [KEY_WIDTH-1:0] max_value,
	output logic [1:0]           status,
	output logic [COUNT_W-1:0]   entry_count
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [KEY_WIDTH-1:0] KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};

	logic [CAP_W-1:0]     cap_q;
	logic [CNT_W-1:0]     count_q;
	logic                 out_valid_q;
	logic [KEY_WIDTH-1:0] max_value_q;
	logic [1:0]           status_q;
	logic [COUNT_W-1:0]   entry_count_q;

	logic [KEY_WIDTH-1:0] cell_key [DEPTH];
	logic                 cell_vld [DEPTH];
	logic                 cell_ge  [DEPTH];
	logic [DEPTH-1:0]     vld_vec;

	logic                 accept;
	logic [CW-1:0]        limit;
	logic                 full;
	logic                 empty;
	cell_ctrl_t           ctrl;
	logic [CNT_W-1:0]     count_nxt;
	logic [KEY_WIDTH-1:0] max_nxt;
	logic [1:0]           status_nxt;

	assign in_stall    = out_valid_q && out_stall;
	assign accept      = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign max_value   = max_value_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

	assign limit = (CW'(cap_q) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_q);
	assign full  = CW'(count_q) >= limit;
	assign empty = (count_q == '0);

	always_comb begin
		ctrl       = '0;
		count_nxt  = count_q;
		max_nxt    = '0;
		status_nxt = STAT_DONE;
		case (req_type)
			REQ_INSERT: begin
				if (full) begin
					status_nxt = STAT_FULL;
				end else begin
					ctrl.ins  = accept;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			REQ_REMOVE: begin
				if (empty) begin
					status_nxt = STAT_EMPTY;
					max_nxt    = KEY_MIN;
				end else begin
					ctrl.rem  = accept;
					max_nxt   = cell_key[0];
					count_nxt = count_q - CNT_W'(1);
				end
			end
			REQ_PEEK: begin
				if (empty) begin
					status_nxt = STAT_EMPTY;
					max_nxt    = KEY_MIN;
				end else begin
					max_nxt = cell_key[0];
				end
			end
			default: begin
				status_nxt = STAT_DONE;
			end
		endcase
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic [KEY_WIDTH-1:0] p_key;
			logic                 p_vld;
			logic                 p_ge;
			logic [KEY_WIDTH-1:0] n_key;
			logic                 n_vld;

			if (i == 0) begin : g_head
				assign p_key = value;
				assign p_vld = 1'b0;
				assign p_ge  = 1'b1;
			end else begin : g_mid
				assign p_key = cell_key[i-1];
				assign p_vld = cell_vld[i-1];
				assign p_ge  = cell_ge[i-1];
			end

			if (i == DEPTH - 1) begin : g_tail
				assign n_key = '0;
				assign n_vld = 1'b0;
			end else begin : g_body
				assign n_key = cell_key[i+1];
				assign n_vld = cell_vld[i+1];
			end

			tmhq_cell #(
				.KEY_WIDTH(KEY_WIDTH)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.key      (value),
				.prev_key (p_key),
				.prev_vld (p_vld),
				.prev_ge  (p_ge),
				.next_key (n_key),
				.next_vld (n_vld),
				.cell_key (cell_key[i]),
				.cell_vld (cell_vld[i]),
				.cell_ge  (cell_ge[i])
			);

			assign vld_vec[i] = cell_vld[i];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_W'(64);
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			max_value_q   <= max_nxt;
			status_q      <= status_nxt;
			entry_count_q <= COUNT_W'(CW'(count_nxt));
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(count_q) <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_valid_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_vec) == int'(count_q))
		else $error("cell valid bits disagree with entry count");

	a_root_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		vld_vec[DEPTH-1:1] != '0 |-> $signed(cell_key[0]) >= $signed(cell_key[1]))
		else $error("root key below its neighbour");

	a_full_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type == REQ_INSERT && full |=> $stable(count_q))
		else $error("refused insert changed the count");
`endif

endmodule

`default_nettype wire

@@ dv/heap_queue_checker.sv @@
`default_nettype none

module heap_queue_checker import tmhq_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire [CAP_W-1:0]   cfg_wdata,
	input  wire               in_valid,
	input  wire               in_stall,
	input  wire [1:0]         req_type,
	input  wire [31:0]        value,
	input  wire               out_valid,
	input  wire               out_stall,
	input  wire [31:0]        max_value,
	input  wire [1:0]         status,
	input  wire [COUNT_W-1:0] entry_count,
	output int                mismatches,
	output int                awaited,
	output int                checked,
	output int                refused,
	output int                empty_reads,
	output int                peak_count
);

	typedef struct packed {
		logic [31:0]        key;
		logic [1:0]         stat;
		logic [COUNT_W-1:0] count;
	} heap_reply_t;

	logic signed [31:0] keys [DEPTH];
	int                 held;
	logic [CAP_W-1:0]   capacity;
	heap_reply_t        replies_due [$];

	function automatic void swap_keys(input int a, input int b);
		logic signed [31:0] t;
		t = keys[a];
		keys[a] = keys[b];
		keys[b] = t;
	endfunction

	function automatic heap_reply_t apply_request(input logic [1:0] req,
			input logic signed [31:0] key);
		heap_reply_t r;
		int lim, k, p, c, best;
		r = '0;
		r.stat = STAT_DONE;
		lim = (capacity > DEPTH) ? DEPTH : int'(capacity);
		case (req)
			REQ_INSERT: begin
				if (held >= lim) begin
					r.stat = STAT_FULL;
				end else begin
					keys[held] = key;
					k = held;
					while (k > 0) begin
						p = (k - 1) / 3;
						if (keys[p] >= keys[k])
							break;
						swap_keys(p, k);
						k = p;
					end
					held++;
				end
			end
			REQ_REMOVE, REQ_PEEK: begin
				if (held == 0) begin
					r.stat = STAT_EMPTY;
					r.key = 32'h8000_0000;
				end else begin
					r.key = keys[0];
					if (req == REQ_REMOVE) begin
						held--;
						keys[0] = keys[held];
						k = 0;
						while (3 * k + 1 < held) begin
							best = 3 * k + 1;
							for (c = best + 1; c <= 3 * k + 3 && c < held; c++)
								if (keys[c] > keys[best])
									best = c;
							if (keys[k] >= keys[best])
								break;
							swap_keys(k, best);
							k = best;
						end
					end
				end
			end
			default: ;
		endcase
		r.count = COUNT_W'(held);
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] %s mismatch: got %0h, expected %0h", $time, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		heap_reply_t want;
		heap_reply_t made;
		if (!arst_n) begin
			held = 0;
			capacity = 7'd64;
			replies_due.delete();
			awaited = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					report_mismatch("unexpected transaction, max_value", max_value, '0);
				end else begin
					want = replies_due.pop_front();
					if (max_value !== want.key)
						report_mismatch("max_value", max_value, want.key);
					if (status !== want.stat)
						report_mismatch("status", 32'(status), 32'(want.stat));
					if (entry_count !== want.count)
						report_mismatch("entry_count", 32'(entry_count),
							32'(want.count));
					checked++;
				end
			end
			if (cfg_we)
				capacity = cfg_wdata;
			if (in_valid && !in_stall) begin
				made = apply_request(req_type, value);
				replies_due.push_back(made);
				if (made.stat == STAT_FULL)
					refused++;
				if (made.stat == STAT_EMPTY)
					empty_reads++;
				if (held > peak_count)
					peak_count = held;
			end
			awaited = replies_due.size();
		end
	end

endmodule

`default_nettype wire

@@ dv/tb_ternary_max_heap_queue.sv @@
`default_nettype none

module tb_ternary_max_heap_queue;
	import tmhq_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int         LIMIT       = 200000;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_we      = 1'b0;
	logic [CAP_W-1:0]   cfg_wdata   = '0;
	logic               in_valid    = 1'b0;
	logic [1:0]         req_type    = REQ_INSERT;
	logic [31:0]        value       = '0;
	logic               out_stall   = 1'b0;
	wire                in_stall;
	wire                out_valid;
	wire [31:0]         max_value;
	wire [1:0]          status;
	wire [COUNT_W-1:0]  entry_count;

	int mismatches, awaited, checked, refused, empty_reads, peak_count;
	int requests_sent = 0;
	int burst_left    = 0;
	int cycle_cnt     = 0;
	bit hold_done     = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	ternary_max_heap_queue #(.DEPTH(64), .KEY_WIDTH(32)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type), .value(value),
		.out_valid(out_valid), .out_stall(out_stall), .max_value(max_value),
		.status(status), .entry_count(entry_count)
	);

	heap_queue_checker #(.DEPTH(64)) chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type), .value(value),
		.out_valid(out_valid), .out_stall(out_stall), .max_value(max_value),
		.status(status), .entry_count(entry_count), .mismatches(mismatches),
		.awaited(awaited), .checked(checked), .refused(refused),
		.empty_reads(empty_reads), .peak_count(peak_count)
	);

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("** ternary_max_heap_queue: FAILED **");
			$finish;
		end
	end

	task automatic offer_request(input logic [1:0] req, input logic [31:0] key);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		req_type <= req;
		value    <= key;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	task automatic wait_drained();
		in_valid   <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (awaited != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [31:0] pick_key();
		case ($urandom_range(0, 9))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2, 3:    return $urandom_range(0, 16) - 8;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [1:0] pick_req(input bit filling);
		int r;
		r = $urandom_range(0, 99);
		if (filling)
			return (r < 85) ? REQ_INSERT : (r < 93) ? REQ_REMOVE
				: (r < 97) ? REQ_PEEK : REQ_UNKNOWN;
		return (r < 15) ? REQ_INSERT : (r < 82) ? REQ_REMOVE
			: (r < 95) ? REQ_PEEK : REQ_UNKNOWN;
	endfunction

	// receiver: windows of differing stall density, one long hold-off mid-run
	initial begin : receiver
		int mode;
		wait (arst_n);
		forever begin
			if (!hold_done && requests_sent >= 350) begin
				out_stall <= 1'b1;
				repeat (150) @(posedge clk);
				hold_done = 1'b1;
			end
			mode = $urandom_range(0, 3);
			repeat (40) begin
				case (mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 3) == 0);
					2:       out_stall <= ($urandom_range(0, 9) < 7);
					default: out_stall <= ~out_stall;
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int caps [7];
		int items [7];
		int ph, n;
		caps  = '{127, 1, 5, 0, 64, 33, 2};
		items = '{150, 80, 100, 40, 200, 100, 80};
		caps[6] = $urandom_range(2, 126);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limit; empty queue, extremes, duplicates, unknown request
		offer_request(REQ_PEEK, 32'h0);
		offer_request(REQ_REMOVE, 32'hFFFF_FFFF);
		offer_request(REQ_UNKNOWN, 32'h1234_5678);
		offer_request(REQ_INSERT, 32'h7FFF_FFFF);
		offer_request(REQ_INSERT, 32'h8000_0000);
		offer_request(REQ_INSERT, 32'h0);
		offer_request(REQ_INSERT, 32'hFFFF_FFFF);
		offer_request(REQ_INSERT, 32'd7);
		offer_request(REQ_INSERT, 32'd7);
		offer_request(REQ_INSERT, 32'd7);
		offer_request(REQ_PEEK, 32'h0);
		offer_request(REQ_UNKNOWN, 32'h0);
		repeat (3) offer_request(REQ_REMOVE, 32'h0);
		offer_request(REQ_PEEK, 32'h0);
		repeat (5) offer_request(REQ_REMOVE, 32'h0);

		// zero limit refuses all inserts; small limit fills and refuses
		set_capacity(7'd0);
		offer_request(REQ_INSERT, 32'd1);
		offer_request(REQ_PEEK, 32'h0);
		set_capacity(7'd2);
		offer_request(REQ_INSERT, 32'd3);
		offer_request(REQ_INSERT, 32'd9);
		offer_request(REQ_INSERT, 32'd1);
		offer_request(REQ_REMOVE, 32'h0);

		for (ph = 0; ph < 7; ph++) begin
			set_capacity(CAP_W'(caps[ph]));
			for (n = 0; n < items[ph]; n++)
				offer_request(pick_req(n < (items[ph] * 3) / 5), pick_key());
		end

		wait_drained();
		repeat (4) @(posedge clk);

		$display("%0d requests sent, %0d results checked over eight limit settings",
			requests_sent, checked);
		$display("%0d inserts refused as full, %0d reads of an empty queue, peak occupancy %0d",
			refused, empty_reads, peak_count);
		if (mismatches == 0) begin
			$display("** ternary_max_heap_queue: PASSED **");
		end else begin
			$display("** ternary_max_heap_queue: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire
